@@ rtl/time_window_latest_per_key_table_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the time window table
// Clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef TIME_WINDOW_LATEST_PER_KEY_TABLE_ASSERT_SVH
`define TIME_WINDOW_LATEST_PER_KEY_TABLE_ASSERT_SVH

// same-cycle implication
`define TWL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/twl_pkg.sv @@
// ---------------------------------------------------------------------------
// twl_pkg
// Types and constants shared by the time window table modules.
// ---------------------------------------------------------------------------
package twl_pkg;

    localparam int KEY_W    = 30;
    localparam int STAMP_W  = 32;
    localparam int DATA_W   = 64;
    localparam int POS_W    = 6;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 7;
    localparam int WIN_W    = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60 * 3);

    localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 4'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_STALE      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_AHEAD      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 4'd4;
    localparam logic [STATUS_W-1:0] ST_ADVANCED   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_READ_OK    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 4'd8;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
        logic [DATA_W-1:0]  data;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        M_NONE,
        M_RECORD,
        M_ADVANCE,
        M_READ
    } mode_t;

endpackage

@@ rtl/twl_cell.sv @@
// ---------------------------------------------------------------------------
// twl_cell
// One table slot: holds, takes its right neighbor, or loads a new entry.
// ---------------------------------------------------------------------------
module twl_cell
    import twl_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    nb,
    input  entry_t    ld,
    output entry_t    q
);

    entry_t q_reg;
    entry_t q_next;

    always_comb
    begin
        case (ctl)
            CELL_SHIFT: q_next = nb;
            CELL_LOAD:  q_next = ld;
            default:    q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/time_window_latest_per_key_table.sv @@
// ---------------------------------------------------------------------------
// time_window_latest_per_key_table
// Insertion-ordered latest-record-per-key table over a sliding time window,
// built as a row of cells that rotates through its head.
// ---------------------------------------------------------------------------
// channel  dir  tdata                              tuser
// s_*      in   vessel_id,stamp,payload,position   kind
// m_*      out  entry_count,vessel_id,stamp,payload status
// cfg_*    in   window_seconds                     -
//
// Record, advance and read items that pass their checks walk the live entries
// through cell 0, one after another; other items, and any item on an empty table, skip the walk.
// One item at a time; the next item is taken while a result waits.
// Reset clears count and time limit and sets the window to 180;
// cell contents stay undefined.
// A stalled result holds the block in its finish state until taken.
// ---------------------------------------------------------------------------
module time_window_latest_per_key_table
    import twl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // vessel_id, stamp, payload, position
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // entry_count, vessel_id, stamp, payload
    output logic [3:0]   m_tuser,   // status
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata  // window_seconds
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    entry_t               new_reg, new_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [STAMP_W-1:0]   start_reg, start_next;
    logic [STAMP_W-1:0]   limit_reg, limit_next;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        total_reg, total_next;
    logic [CW-1:0]        j_reg, j_next;
    logic                 found_reg, found_next;
    entry_t               rd_reg, rd_next;
    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           out_user_reg, out_user_next;
    logic [135:0]         out_data_reg, out_data_next;

    entry_t               cell_q [TABLE_DEPTH];
    cell_ctl_t            cell_ctl [TABLE_DEPTH];
    entry_t               head;
    entry_t               load_src;
    entry_t               in_entry;
    entry_t               out_entry;
    logic [KIND_W-1:0]    in_kind;
    logic [POS_W-1:0]     in_pos;
    logic [STAMP_W-1:0]   cur_start;
    logic [STAMP_W-1:0]   adv_start;
    logic                 keep;
    logic                 out_free;
    logic                 append;
    logic [CW-1:0]        count_after;

    assign in_entry.key   = s_tdata[29:0];
    assign in_entry.stamp = s_tdata[61:30];
    assign in_entry.data  = s_tdata[125:62];
    assign in_pos         = s_tdata[131:126];
    assign in_kind        = s_tuser;

    assign head     = cell_q[0];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign load_src = (state_reg == S_WALK) ? head : new_reg;

    assign cur_start = (limit_reg >= STAMP_W'(window_reg)) ?
                       limit_reg - STAMP_W'(window_reg) : '0;
    assign adv_start = (in_entry.stamp >= STAMP_W'(window_reg)) ?
                       in_entry.stamp - STAMP_W'(window_reg) : '0;

    always_comb
    begin
        case (mode_reg)
            M_RECORD:  keep = (head.key != new_reg.key);
            M_ADVANCE: keep = (head.stamp >= start_reg);
            default:   keep = 1'b1;
        endcase
    end

    assign append = (mode_reg == M_RECORD) && (count_reg < CW'(TABLE_DEPTH));

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t nb;

            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign nb = cell_q[gi];
            end
            else
            begin : g_mid
                assign nb = cell_q[gi + 1];
            end

            always_comb
            begin
                cell_ctl[gi] = CELL_HOLD;
                if (state_reg == S_WALK)
                begin
                    if (CW'(gi + 1) < count_reg)
                        cell_ctl[gi] = CELL_SHIFT;
                    else if (CW'(gi + 1) == count_reg && keep)
                        cell_ctl[gi] = CELL_LOAD;
                end
                else if (state_reg == S_FINISH && out_free && append &&
                         CW'(gi) == count_reg)
                begin
                    cell_ctl[gi] = CELL_LOAD;
                end
            end

            twl_cell u_cell (
                .clk (clk),
                .ctl (cell_ctl[gi]),
                .nb  (nb),
                .ld  (load_src),
                .q   (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        new_next       = new_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        limit_next     = limit_reg;
        window_next    = cfg_we ? cfg_wdata : window_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        j_next         = j_reg;
        found_next     = found_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_user_next  = out_user_reg;
        out_data_next  = out_data_reg;
        count_after    = count_reg;
        out_entry      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    new_next   = in_entry;
                    pos_next   = in_pos;
                    total_next = count_reg;
                    j_next     = '0;
                    found_next = 1'b0;
                    mode_next  = M_NONE;
                    case (in_kind)
                        KIND_RECORD:
                        begin
                            if (in_entry.stamp > limit_reg)
                                status_next = ST_AHEAD;
                            else if (in_entry.stamp < cur_start)
                                status_next = ST_STALE;
                            else
                                mode_next = M_RECORD;
                        end
                        KIND_ADVANCE:
                        begin
                            if (in_entry.stamp < limit_reg)
                                status_next = ST_REJECTED;
                            else
                            begin
                                mode_next   = M_ADVANCE;
                                status_next = ST_ADVANCED;
                                limit_next  = in_entry.stamp;
                                start_next  = adv_start;
                            end
                        end
                        KIND_READ:
                        begin
                            if (32'(in_pos) < 32'(count_reg))
                                mode_next = M_READ;
                            else
                                status_next = ST_READ_EMPTY;
                        end
                        default: status_next = ST_READ_EMPTY;
                    endcase
                    if (mode_next == M_NONE || count_reg == '0)
                        state_next = S_FINISH;
                    else
                        state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (!keep)
                    count_next = count_reg - 1'b1;
                if (mode_reg == M_RECORD && !keep)
                    found_next = 1'b1;
                if (mode_reg == M_READ && 32'(pos_reg) == 32'(j_reg))
                    rd_next = head;
                j_next = j_reg + 1'b1;
                if (j_reg == total_reg - 1'b1)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_user_next = status_reg;
                    if (mode_reg == M_RECORD)
                    begin
                        count_after = count_reg + CW'(append);
                        if (found_reg)
                            out_user_next = ST_REPLACED;
                        else if (append)
                            out_user_next = ST_INSERTED;
                        else
                            out_user_next = ST_FULL;
                    end
                    else if (mode_reg == M_READ)
                    begin
                        out_user_next = ST_READ_OK;
                        out_entry     = rd_reg;
                    end
                    count_next     = count_after;
                    out_data_next  = {3'b000, out_entry.data, out_entry.stamp,
                                      out_entry.key, COUNT_W'(count_after)};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_NONE;
            limit_reg     <= '0;
            window_reg    <= WINDOW_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            limit_reg     <= limit_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        new_reg      <= new_next;
        pos_reg      <= pos_next;
        start_reg    <= start_next;
        total_reg    <= total_next;
        j_reg        <= j_next;
        found_reg    <= found_next;
        rd_reg       <= rd_next;
        out_user_reg <= out_user_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/twl_checker.sv @@
// ---------------------------------------------------------------------------
// twl_checker
// Port-level checks on the time window table, bound to the top level.
// ---------------------------------------------------------------------------
`include "time_window_latest_per_key_table_assert.svh"

module twl_checker
    import twl_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [3:0]   m_tuser
);

    `TWL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `TWL_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= ST_READ_EMPTY, "status out of range")
    `TWL_ASSERT_NOW(a_fields_zero, m_tvalid && m_tuser != ST_READ_OK, m_tdata[132:7] == '0, "entry fields set without a read")
    `TWL_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item taken while busy")

endmodule

bind time_window_latest_per_key_table twl_checker u_twl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
